>>> sv/adaptive_measurement_covariance_core_assert.svh
// Assertion macros for the covariance core; aclk and aresetn are taken from the using scope.
`ifndef ADAPTIVE_MEASUREMENT_COVARIANCE_CORE_ASSERT_SVH
`define ADAPTIVE_MEASUREMENT_COVARIANCE_CORE_ASSERT_SVH

// Same-cycle implication.
`define AMC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define AMC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/amc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package amc_pkg;

    localparam int DATA_W         = 32;
    localparam int SUM_W          = 56;
    localparam int SAT_W          = SUM_W + 2;
    localparam int OBS_DIM_DEF    = 4;
    localparam int STATE_DIM_DEF  = 8;
    localparam int WINDOW_MAX_DEF = 64;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int WL_W           = 7;
    localparam int SRC_W          = 8;
    localparam int IDX_W          = 4;
    localparam int OUT_IDX_W      = 3;
    localparam int OPC_W          = 3;
    localparam int S_TDATA_W      = 48;
    localparam int M_TDATA_W      = 40;
    localparam int CFG_ADDR_W     = 1;
    localparam int CFG_DATA_W     = 8;

    localparam logic [WL_W-1:0]       WL_RESET          = 7'd16;
    localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_LENGTH = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SOURCE_ID     = 1'b1;

    typedef enum logic [OPC_W-1:0] {
        OP_INNOV    = 3'd0,
        OP_MEAS     = 3'd1,
        OP_POST_COV = 3'd2,
        OP_COMMIT   = 3'd3,
        OP_INIT_COV = 3'd4,
        OP_REQUEST  = 3'd5
    } opcode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_MUL,
        ST_ACC,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_BUMP,
        ST_TRIM,
        ST_REQ_ELEM,
        ST_REQ_DIV,
        ST_REQ_EMIT
    } state_t;

    typedef enum logic [1:0] {
        PH_HP,
        PH_HPH,
        PH_DROP,
        PH_PUSH
    } phase_t;

    typedef struct packed {
        logic innov;
        logic meas;
        logic post;
        logic hp;
        logic ring;
    } store_we_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] x);
        logic [SAT_W-DATA_W:0] top;
        begin
            top = x[SAT_W-1:DATA_W-1];
            if ((&top) || !(|top)) begin
                sat32 = x[DATA_W-1:0];
            end else if (x[SAT_W-1]) begin
                sat32 = {1'b1, {(DATA_W-1){1'b0}}};
            end else begin
                sat32 = {1'b0, {(DATA_W-1){1'b1}}};
            end
        end
    endfunction

endpackage
`default_nettype wire

>>> sv/amc_store.sv
`timescale 1ns / 1ps
`default_nettype none
module amc_store #(
    parameter int OBS_DIM    = amc_pkg::OBS_DIM_DEF,
    parameter int STATE_DIM  = amc_pkg::STATE_DIM_DEF,
    parameter int WINDOW_MAX = amc_pkg::WINDOW_MAX_DEF
) (
    input  wire logic                              clk,
    input  wire amc_pkg::store_we_t                we,
    input  wire logic [amc_pkg::DATA_W-1:0]        wdata,
    input  wire logic [((OBS_DIM > 1) ? $clog2(OBS_DIM) : 1)-1:0] innov_wa,
    input  wire logic [((OBS_DIM > 1) ? $clog2(OBS_DIM) : 1)-1:0] innov_ra0,
    input  wire logic [((OBS_DIM > 1) ? $clog2(OBS_DIM) : 1)-1:0] innov_ra1,
    input  wire logic [((OBS_DIM > 1) ? $clog2(OBS_DIM) : 1)
                       + ((STATE_DIM > 1) ? $clog2(STATE_DIM) : 1)-1:0] h_wa,
    input  wire logic [((OBS_DIM > 1) ? $clog2(OBS_DIM) : 1)
                       + ((STATE_DIM > 1) ? $clog2(STATE_DIM) : 1)-1:0] h_ra,
    input  wire logic [2*((STATE_DIM > 1) ? $clog2(STATE_DIM) : 1)-1:0] p_wa,
    input  wire logic [2*((STATE_DIM > 1) ? $clog2(STATE_DIM) : 1)-1:0] p_ra,
    input  wire logic [((OBS_DIM > 1) ? $clog2(OBS_DIM) : 1)
                       + ((STATE_DIM > 1) ? $clog2(STATE_DIM) : 1)-1:0] hp_wa,
    input  wire logic [((OBS_DIM > 1) ? $clog2(OBS_DIM) : 1)
                       + ((STATE_DIM > 1) ? $clog2(STATE_DIM) : 1)-1:0] hp_ra,
    input  wire logic [((WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1)
                       + ((OBS_DIM > 1) ? $clog2(OBS_DIM) : 1)-1:0] ring_wa,
    input  wire logic [((WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1)
                       + ((OBS_DIM > 1) ? $clog2(OBS_DIM) : 1)-1:0] ring_ra0,
    input  wire logic [((WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1)
                       + ((OBS_DIM > 1) ? $clog2(OBS_DIM) : 1)-1:0] ring_ra1,
    output logic signed [amc_pkg::DATA_W-1:0]      innov_q0,
    output logic signed [amc_pkg::DATA_W-1:0]      innov_q1,
    output logic signed [amc_pkg::DATA_W-1:0]      h_q,
    output logic signed [amc_pkg::DATA_W-1:0]      p_q,
    output logic signed [amc_pkg::DATA_W-1:0]      hp_q,
    output logic signed [amc_pkg::DATA_W-1:0]      ring_q0,
    output logic signed [amc_pkg::DATA_W-1:0]      ring_q1
);

    localparam int OW = (OBS_DIM > 1) ? $clog2(OBS_DIM) : 1;
    localparam int SW = (STATE_DIM > 1) ? $clog2(STATE_DIM) : 1;
    localparam int RW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    logic [amc_pkg::DATA_W-1:0] innov_mem [2**OW];
    logic [amc_pkg::DATA_W-1:0] h_mem     [2**(OW+SW)];
    logic [amc_pkg::DATA_W-1:0] p_mem     [2**(2*SW)];
    logic [amc_pkg::DATA_W-1:0] hp_mem    [2**(OW+SW)];
    logic [amc_pkg::DATA_W-1:0] ring_mem  [2**(RW+OW)];

    always_ff @(posedge clk) begin
        if (we.innov) begin
            innov_mem[innov_wa] <= wdata;
        end
        innov_q0 <= innov_mem[innov_ra0];
        innov_q1 <= innov_mem[innov_ra1];
    end

    always_ff @(posedge clk) begin
        if (we.meas) begin
            h_mem[h_wa] <= wdata;
        end
        h_q <= h_mem[h_ra];
    end

    always_ff @(posedge clk) begin
        if (we.post) begin
            p_mem[p_wa] <= wdata;
        end
        p_q <= p_mem[p_ra];
    end

    always_ff @(posedge clk) begin
        if (we.hp) begin
            hp_mem[hp_wa] <= wdata;
        end
        hp_q <= hp_mem[hp_ra];
    end

    always_ff @(posedge clk) begin
        if (we.ring) begin
            ring_mem[ring_wa] <= wdata;
        end
        ring_q0 <= ring_mem[ring_ra0];
        ring_q1 <= ring_mem[ring_ra1];
    end

endmodule
`default_nettype wire

>>> sv/amc_mac.sv
`timescale 1ns / 1ps
`default_nettype none
module amc_mac #(
    parameter int FRAC_BITS = amc_pkg::FRAC_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               en,
    input  wire logic signed [amc_pkg::DATA_W-1:0]  a,
    input  wire logic signed [amc_pkg::DATA_W-1:0]  b,
    output logic signed [amc_pkg::SUM_W-1:0]        rnd
);

    localparam int PROD_W = 2 * amc_pkg::DATA_W;
    localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] biased;
    logic signed [PROD_W-1:0] shifted;

    always_ff @(posedge clk) begin
        if (en) begin
            prod_reg <= PROD_W'(a) * PROD_W'(b);
        end
    end

    // round half up to the fraction point
    assign biased  = prod_reg + HALF;
    assign shifted = biased >>> FRAC_BITS;
    assign rnd     = shifted[amc_pkg::SUM_W-1:0];

endmodule
`default_nettype wire

>>> sv/amc_div.sv
`timescale 1ns / 1ps
`default_nettype none
module amc_div #(
    parameter int NUM_W = amc_pkg::SUM_W,
    parameter int DEN_W = $clog2(amc_pkg::WINDOW_MAX_DEF + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic [NUM_W-1:0]      quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic             fits;
    logic [DEN_W:0]   diff;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= CNT_W'(NUM_W);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // one quotient bit a cycle, restoring
    always_ff @(posedge clk) begin
        if (start) begin
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= num;
        end else if (cnt_reg != '0) begin
            rem_reg <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule
`default_nettype wire

>>> sv/adaptive_measurement_covariance_core.sv
// Load, initial-covariance and ignored words: accepted while idle, and the core stays idle with s_tready high.
// Commit: HP and HPH projection passes, window drops and the innovation push, all on the one MAC;
//   each MAC step runs through ST_RD, ST_MUL and ST_ACC, and each dropped window entry adds a drop pass.
// Request: OBS*OBS result words; an adaptive word goes through the serial divider, an
//   initial-covariance word skips it; a full output register stalls the run.
// aresetn (synchronous): window empty, sums and projection zero, initial covariance identity.
`timescale 1ns / 1ps
`default_nettype none
module adaptive_measurement_covariance_core #(
    parameter int OBS_DIM    = amc_pkg::OBS_DIM_DEF,
    parameter int STATE_DIM  = amc_pkg::STATE_DIM_DEF,
    parameter int WINDOW_MAX = amc_pkg::WINDOW_MAX_DEF,
    parameter int FRAC_BITS  = amc_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // source [7:0], row [11:8], col [15:12], elem_value [47:16]
    input  wire logic [amc_pkg::S_TDATA_W-1:0]     s_tdata,
    // opcode [2:0]
    input  wire logic [amc_pkg::OPC_W-1:0]         s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // out_row [2:0], out_col [5:3], cov_value [37:6], zero [39:38]
    output logic [amc_pkg::M_TDATA_W-1:0]          m_tdata,
    // adaptive [0]
    output logic [0:0]                             m_tuser,
    output logic                                   m_tlast,
    input  wire logic                              cfg_wr_en,
    input  wire logic [amc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [amc_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);

`include "adaptive_measurement_covariance_core_assert.svh"

    localparam int OW = (OBS_DIM > 1) ? $clog2(OBS_DIM) : 1;
    localparam int SW = (STATE_DIM > 1) ? $clog2(STATE_DIM) : 1;
    localparam int MW = (OW > SW) ? OW : SW;
    localparam int RW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int DW = amc_pkg::DATA_W;
    localparam int SUMW = amc_pkg::SUM_W;
    localparam int SATW = amc_pkg::SAT_W;

    amc_pkg::state_t state_reg, state_next;
    amc_pkg::phase_t phase_reg;

    logic [amc_pkg::WL_W-1:0]  wl_reg;
    logic [amc_pkg::SRC_W-1:0] src_id_reg;
    logic [CW-1:0]             fill_reg;
    logic [RW-1:0]             head_reg;
    logic                      pushed_reg;
    logic [OW-1:0]             ci_reg;
    logic [MW-1:0]             cc_reg;
    logic [SW-1:0]             ck_reg;
    logic signed [SUMW-1:0]    acc_reg;
    logic signed [SUMW-1:0]    outer_reg [OBS_DIM][OBS_DIM];
    logic signed [DW-1:0]      proj_reg  [OBS_DIM][OBS_DIM];
    logic signed [DW-1:0]      init_reg  [OBS_DIM][OBS_DIM];
    logic                      adaptive_reg;
    logic                      sign_reg;
    logic signed [DW-1:0]      val_reg;
    logic                      m_valid_reg;
    logic [amc_pkg::OUT_IDX_W-1:0] m_row_reg;
    logic [amc_pkg::OUT_IDX_W-1:0] m_col_reg;
    logic [DW-1:0]             m_cov_reg;
    logic                      m_adapt_reg;
    logic                      m_last_reg;

    // input word fields
    logic [amc_pkg::SRC_W-1:0] in_src;
    logic [amc_pkg::IDX_W-1:0] in_row;
    logic [amc_pkg::IDX_W-1:0] in_col;
    logic [DW-1:0]             in_val;
    logic                      in_fire;
    logic                      src_ok;
    logic                      row_obs, col_obs, row_st, col_st;
    logic                      op_commit, op_request, op_init;

    assign in_src  = s_tdata[7:0];
    assign in_row  = s_tdata[11:8];
    assign in_col  = s_tdata[15:12];
    assign in_val  = s_tdata[47:16];
    assign in_fire = s_tvalid && s_tready;
    assign src_ok  = (s_tuser > amc_pkg::OP_COMMIT) || (in_src == src_id_reg);
    assign row_obs = {1'b0, in_row} < 5'(OBS_DIM);
    assign col_obs = {1'b0, in_col} < 5'(OBS_DIM);
    assign row_st  = {1'b0, in_row} < 5'(STATE_DIM);
    assign col_st  = {1'b0, in_col} < 5'(STATE_DIM);
    assign op_commit  = in_fire && (s_tuser == amc_pkg::OP_COMMIT) && src_ok;
    assign op_request = in_fire && (s_tuser == amc_pkg::OP_REQUEST);
    assign op_init    = in_fire && (s_tuser == amc_pkg::OP_INIT_COV) && row_obs && col_obs;

    // effective window length and oldest slot
    logic [8:0]    wl_wide;
    logic [CW-1:0] eff_win;
    logic [CW:0]   slot_diff, slot_wrap;
    logic [RW-1:0] slot;
    logic          fill_full;

    assign wl_wide   = 9'(wl_reg);
    assign eff_win   = (wl_reg == '0) ? CW'(1) :
                       (wl_wide > 9'(WINDOW_MAX)) ? CW'(WINDOW_MAX) : CW'(wl_reg);
    assign slot_diff = (CW+1)'(head_reg) - (CW+1)'(fill_reg);
    assign slot_wrap = slot_diff[CW] ? slot_diff + (CW+1)'(WINDOW_MAX) : slot_diff;
    assign slot      = slot_wrap[RW-1:0];
    assign fill_full = fill_reg == CW'(WINDOW_MAX);

    // loop bounds
    logic [OW-1:0] cco;
    logic          i_last, k_last, c_last, obs_c_last, phase_end, req_last;

    assign cco        = cc_reg[OW-1:0];
    assign i_last     = ci_reg == OW'(OBS_DIM - 1);
    assign obs_c_last = cc_reg == MW'(OBS_DIM - 1);
    assign k_last     = ((phase_reg == amc_pkg::PH_HP) || (phase_reg == amc_pkg::PH_HPH)) ?
                        (ck_reg == SW'(STATE_DIM - 1)) : 1'b1;
    assign c_last     = (phase_reg == amc_pkg::PH_HP) ? (cc_reg == MW'(STATE_DIM - 1)) :
                        obs_c_last;
    assign phase_end  = k_last && c_last && i_last;
    assign req_last   = i_last && obs_c_last;

    // shared units
    amc_pkg::store_we_t   we;
    logic [DW-1:0]        wdata;
    logic signed [DW-1:0] innov_q0, innov_q1, h_q, p_q, hp_q, ring_q0, ring_q1;
    logic signed [DW-1:0] op_a, op_b;
    logic                 mac_en;
    logic signed [SUMW-1:0] rnd;
    logic signed [SUMW-1:0] mac_sum;
    logic signed [SUMW-1:0] sum_elem;
    logic signed [DW-1:0]   sum_sat;
    logic [OW+SW-1:0]       h_ra;
    logic                   div_start, div_done;
    logic [SUMW-1:0]        div_num, div_quot, elem_mag;
    logic signed [SATW-1:0] q_signed, adapt_sum;

    assign sum_elem = outer_reg[ci_reg][cco];
    assign mac_sum  = acc_reg + rnd;
    assign sum_sat  = amc_pkg::sat32(SATW'(mac_sum));
    assign h_ra     = (phase_reg == amc_pkg::PH_HP) ? {ci_reg, ck_reg} : {cco, ck_reg};
    assign elem_mag = sum_elem[SUMW-1] ? SUMW'(-sum_elem) : SUMW'(sum_elem);
    assign div_num  = elem_mag + SUMW'(fill_reg >> 1);
    assign q_signed = sign_reg ? -signed'(SATW'(div_quot)) : signed'(SATW'(div_quot));
    assign adapt_sum = q_signed + SATW'(proj_reg[ci_reg][cco]);

    always_comb begin
        unique case (phase_reg)
            amc_pkg::PH_HP: begin
                op_a = h_q;
                op_b = p_q;
            end
            amc_pkg::PH_HPH: begin
                op_a = hp_q;
                op_b = h_q;
            end
            amc_pkg::PH_DROP: begin
                op_a = ring_q0;
                op_b = ring_q1;
            end
            amc_pkg::PH_PUSH: begin
                op_a = innov_q0;
                op_b = innov_q1;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    amc_store #(
        .OBS_DIM    (OBS_DIM),
        .STATE_DIM  (STATE_DIM),
        .WINDOW_MAX (WINDOW_MAX)
    ) u_store (
        .clk       (aclk),
        .we        (we),
        .wdata     (wdata),
        .innov_wa  (in_row[OW-1:0]),
        .innov_ra0 (ci_reg),
        .innov_ra1 (cco),
        .h_wa      ({in_row[OW-1:0], in_col[SW-1:0]}),
        .h_ra      (h_ra),
        .p_wa      ({in_row[SW-1:0], in_col[SW-1:0]}),
        .p_ra      ({ck_reg, cc_reg[SW-1:0]}),
        .hp_wa     ({ci_reg, cc_reg[SW-1:0]}),
        .hp_ra     ({ci_reg, ck_reg}),
        .ring_wa   ({head_reg, ci_reg}),
        .ring_ra0  ({slot, ci_reg}),
        .ring_ra1  ({slot, cco}),
        .innov_q0  (innov_q0),
        .innov_q1  (innov_q1),
        .h_q       (h_q),
        .p_q       (p_q),
        .hp_q      (hp_q),
        .ring_q0   (ring_q0),
        .ring_q1   (ring_q1)
    );

    amc_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .clk (aclk),
        .en  (mac_en),
        .a   (op_a),
        .b   (op_b),
        .rnd (rnd)
    );

    amc_div #(
        .NUM_W (SUMW),
        .DEN_W (CW)
    ) u_div (
        .clk   (aclk),
        .rst_n (aresetn),
        .start (div_start),
        .num   (div_num),
        .den   (fill_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    logic out_free;
    assign out_free = !m_valid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            amc_pkg::ST_IDLE: begin
                if (op_commit) begin
                    state_next = amc_pkg::ST_RD;
                end else if (op_request) begin
                    state_next = amc_pkg::ST_REQ_ELEM;
                end
            end
            amc_pkg::ST_RD:  state_next = amc_pkg::ST_MUL;
            amc_pkg::ST_MUL: state_next = amc_pkg::ST_ACC;
            amc_pkg::ST_ACC: begin
                if (!phase_end) begin
                    state_next = amc_pkg::ST_RD;
                end else begin
                    unique case (phase_reg)
                        amc_pkg::PH_HP:   state_next = amc_pkg::ST_RD;
                        amc_pkg::PH_HPH:  state_next = fill_full ? amc_pkg::ST_RD :
                                                                   amc_pkg::ST_COPY_RD;
                        amc_pkg::PH_DROP: state_next = pushed_reg ? amc_pkg::ST_TRIM :
                                                                    amc_pkg::ST_COPY_RD;
                        amc_pkg::PH_PUSH: state_next = amc_pkg::ST_BUMP;
                        default:          state_next = amc_pkg::ST_IDLE;
                    endcase
                end
            end
            amc_pkg::ST_COPY_RD: state_next = amc_pkg::ST_COPY_WR;
            amc_pkg::ST_COPY_WR: state_next = i_last ? amc_pkg::ST_RD : amc_pkg::ST_COPY_RD;
            amc_pkg::ST_BUMP:    state_next = amc_pkg::ST_TRIM;
            amc_pkg::ST_TRIM:    state_next = (fill_reg > eff_win) ? amc_pkg::ST_RD :
                                                                     amc_pkg::ST_IDLE;
            amc_pkg::ST_REQ_ELEM: state_next = adaptive_reg ? amc_pkg::ST_REQ_DIV :
                                                              amc_pkg::ST_REQ_EMIT;
            amc_pkg::ST_REQ_DIV: begin
                if (div_done) begin
                    state_next = amc_pkg::ST_REQ_EMIT;
                end
            end
            amc_pkg::ST_REQ_EMIT: begin
                if (out_free) begin
                    state_next = req_last ? amc_pkg::ST_IDLE : amc_pkg::ST_REQ_ELEM;
                end
            end
            default: state_next = amc_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_tready  = state_reg == amc_pkg::ST_IDLE;
        mac_en    = state_reg == amc_pkg::ST_MUL;
        div_start = (state_reg == amc_pkg::ST_REQ_ELEM) && adaptive_reg;
        we.innov  = in_fire && (s_tuser == amc_pkg::OP_INNOV) && src_ok && row_obs;
        we.meas   = in_fire && (s_tuser == amc_pkg::OP_MEAS) && src_ok && row_obs && col_st;
        we.post   = in_fire && (s_tuser == amc_pkg::OP_POST_COV) && src_ok && row_st && col_st;
        we.hp     = (state_reg == amc_pkg::ST_ACC) && (phase_reg == amc_pkg::PH_HP) && k_last;
        we.ring   = state_reg == amc_pkg::ST_COPY_WR;
        if (state_reg == amc_pkg::ST_ACC) begin
            wdata = sum_sat;
        end else if (state_reg == amc_pkg::ST_COPY_WR) begin
            wdata = innov_q0;
        end else begin
            wdata = in_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= amc_pkg::ST_IDLE;
            phase_reg    <= amc_pkg::PH_HP;
            wl_reg       <= amc_pkg::WL_RESET;
            src_id_reg   <= '0;
            fill_reg     <= '0;
            head_reg     <= '0;
            pushed_reg   <= 1'b0;
            ci_reg       <= '0;
            cc_reg       <= '0;
            ck_reg       <= '0;
            acc_reg      <= '0;
            adaptive_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < OBS_DIM; i++) begin
                for (int j = 0; j < OBS_DIM; j++) begin
                    outer_reg[i][j] <= '0;
                    proj_reg[i][j]  <= '0;
                    init_reg[i][j]  <= (i == j) ? DW'(1) << FRAC_BITS : '0;
                end
            end
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    amc_pkg::CFG_WINDOW_LENGTH: wl_reg <= cfg_wr_data[amc_pkg::WL_W-1:0];
                    amc_pkg::CFG_SOURCE_ID:     src_id_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                amc_pkg::ST_IDLE: begin
                    if (op_commit) begin
                        phase_reg  <= amc_pkg::PH_HP;
                        pushed_reg <= 1'b0;
                        ci_reg     <= '0;
                        cc_reg     <= '0;
                        ck_reg     <= '0;
                        acc_reg    <= '0;
                    end
                    if (op_request) begin
                        ci_reg       <= '0;
                        cc_reg       <= '0;
                        adaptive_reg <= fill_reg >= eff_win;
                    end
                    if (op_init) begin
                        init_reg[in_row[OW-1:0]][in_col[OW-1:0]] <= in_val;
                    end
                end
                amc_pkg::ST_ACC: begin
                    ck_reg  <= k_last ? '0 : ck_reg + SW'(1);
                    acc_reg <= k_last ? '0 : mac_sum;
                    if (k_last) begin
                        cc_reg <= c_last ? '0 : cc_reg + MW'(1);
                        if (c_last) begin
                            ci_reg <= i_last ? '0 : ci_reg + OW'(1);
                        end
                    end
                    if ((phase_reg == amc_pkg::PH_HPH) && k_last) begin
                        proj_reg[ci_reg][cco] <= sum_sat;
                    end
                    if (phase_reg == amc_pkg::PH_DROP) begin
                        outer_reg[ci_reg][cco] <= sum_elem - rnd;
                    end
                    if (phase_reg == amc_pkg::PH_PUSH) begin
                        outer_reg[ci_reg][cco] <= sum_elem + rnd;
                    end
                    if (phase_end) begin
                        unique case (phase_reg)
                            amc_pkg::PH_HP:   phase_reg <= amc_pkg::PH_HPH;
                            amc_pkg::PH_HPH: begin
                                if (fill_full) begin
                                    phase_reg <= amc_pkg::PH_DROP;
                                end
                            end
                            amc_pkg::PH_DROP: fill_reg <= fill_reg - CW'(1);
                            amc_pkg::PH_PUSH: ;
                            default: ;
                        endcase
                    end
                end
                amc_pkg::ST_COPY_WR: begin
                    ci_reg <= i_last ? '0 : ci_reg + OW'(1);
                    if (i_last) begin
                        phase_reg <= amc_pkg::PH_PUSH;
                    end
                end
                amc_pkg::ST_BUMP: begin
                    head_reg   <= (head_reg == RW'(WINDOW_MAX - 1)) ? '0 : head_reg + RW'(1);
                    fill_reg   <= fill_reg + CW'(1);
                    pushed_reg <= 1'b1;
                end
                amc_pkg::ST_TRIM: begin
                    // shed entries beyond the window, oldest first
                    if (fill_reg > eff_win) begin
                        phase_reg <= amc_pkg::PH_DROP;
                    end
                end
                amc_pkg::ST_REQ_ELEM: sign_reg <= sum_elem[SUMW-1];
                amc_pkg::ST_REQ_DIV: begin
                    if (div_done) begin
                        val_reg <= amc_pkg::sat32(adapt_sum);
                    end
                end
                amc_pkg::ST_REQ_EMIT: begin
                    if (out_free) begin
                        cc_reg <= obs_c_last ? '0 : cc_reg + MW'(1);
                        if (obs_c_last) begin
                            ci_reg <= i_last ? '0 : ci_reg + OW'(1);
                        end
                    end
                end
                default: ;
            endcase
            if ((state_reg == amc_pkg::ST_REQ_EMIT) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // output word payload
    always_ff @(posedge aclk) begin
        if ((state_reg == amc_pkg::ST_REQ_EMIT) && out_free) begin
            m_row_reg   <= amc_pkg::OUT_IDX_W'(ci_reg);
            m_col_reg   <= amc_pkg::OUT_IDX_W'(cco);
            m_cov_reg   <= adaptive_reg ? val_reg : init_reg[ci_reg][cco];
            m_adapt_reg <= adaptive_reg;
            m_last_reg  <= req_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_cov_reg, m_col_reg, m_row_reg};
    assign m_tuser  = m_adapt_reg;
    assign m_tlast  = m_last_reg;

    `AMC_ASSERT_IMP(a_fill_bound, 1'b1, fill_reg <= CW'(WINDOW_MAX),
        "window fill beyond ring depth")
    `AMC_ASSERT_NXT(a_commit_start, op_commit,
        state_reg == amc_pkg::ST_RD && phase_reg == amc_pkg::PH_HP && ci_reg == '0,
        "commit did not start the projection pass")
    `AMC_ASSERT_NXT(a_idle_window, state_reg == amc_pkg::ST_IDLE && !in_fire,
        $stable(fill_reg) && $stable(head_reg), "window moved while idle")
    `AMC_ASSERT_IMP(a_last_pos, m_tvalid && m_tlast,
        m_tdata[2:0] == 3'(OBS_DIM - 1) && m_tdata[5:3] == 3'(OBS_DIM - 1),
        "run end flagged away from the final element")

endmodule
`default_nettype wire
